// ===== hdl/kdhr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kdhr_pkg
// Types and constants for the two-key debouncer with hold and auto-repeat.
// ----------------------------------------------------------------------------
package kdhr_pkg;

   // field widths
   localparam int unsigned TimeWidth = 32;
   localparam int unsigned SetWidth  = 16;
   localparam int unsigned CodeWidth = 2;

   // stream payload widths, padded to whole bytes
   localparam int unsigned ReqDataWidth = 40;
   localparam int unsigned RspDataWidth = 8;

   // register file port
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;

   typedef logic [CodeWidth-1:0] key_code_type;
   typedef logic [SetWidth-1:0]  set_ms_type;
   typedef logic [TimeWidth-1:0] time_ms_type;

   // key codes
   localparam key_code_type KEY_NONE = 2'd0;
   localparam key_code_type KEY_ONE  = 2'd1;
   localparam key_code_type KEY_TWO  = 2'd2;

   // register indexes (byte address bits [3:2])
   typedef enum logic [1:0] {
      REG_DEBOUNCE = 2'd0,
      REG_HOLD     = 2'd1,
      REG_REPEAT   = 2'd2
   } reg_index_type;

   // register reset values
   localparam set_ms_type DEBOUNCE_RESET = 16'd20;
   localparam set_ms_type HOLD_RESET     = 16'd1000;
   localparam set_ms_type REPEAT_RESET   = 16'd200;

   // key tracking phases
   typedef enum logic [5:0] {
      PH_UP       = 6'b000001,
      PH_DEBOUNCE = 6'b000010,
      PH_PRESSED  = 6'b000100,
      PH_DOWN     = 6'b001000,
      PH_HELD     = 6'b010000,
      PH_RELEASED = 6'b100000
   } phase_type;

endpackage : kdhr_pkg
`default_nettype wire

// ===== hdl/key_debounce_hold_repeat_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_debounce_hold_repeat_core
// Debounced reader for two active-low keys with hold detection and
// auto-repeat, fed by polls that carry the pin levels and a millisecond time.
// ----------------------------------------------------------------------------
// Each poll accepted on req_ yields exactly one key_code on rsp_, in order.
// One poll is taken every clock cycle while req_tready is high. A poll is
// held in the input register and then moves into the result register,
// from which its result is offered on rsp_. The key tracking state is
// updated as the poll moves from the input register into the result
// register. Back-pressure on rsp_ holds the result register and then the
// input register; req_tready stays high while either has room. Key two
// wins over key one. A code is reported when the debounce time has passed,
// on every repeat interval while held, and on release from the held phase;
// all other polls report zero. Elapsed time is now_ms minus the last mark
// modulo 2^32, compared strictly greater than the setting. Registers at
// byte addresses 0, 4 and 8 hold debounce_ms, hold_ms and repeat_ms (16
// bits each) and should be written only while idle.
// ----------------------------------------------------------------------------
module key_debounce_hold_repeat_core (
   input  wire                                 clock,
   input  wire                                 reset,
   // poll stream
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // [0] key1_level, [1] key2_level, [33:2] now_ms, [39:34] zero
   input  wire  [kdhr_pkg::ReqDataWidth-1:0]   req_tdata,
   // result stream
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // [1:0] key_code, [7:2] zero
   output logic [kdhr_pkg::RspDataWidth-1:0]   rsp_tdata,
   // register port
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [kdhr_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  wire  [kdhr_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [kdhr_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import kdhr_pkg::*;

   // settings
   set_ms_type    debounce_ff;
   set_ms_type    hold_ff;
   set_ms_type    repeat_ff;
   logic          csr_write;
   reg_index_type csr_index;

   // input register
   logic          in_valid_ff;
   logic          in_key1_ff;
   logic          in_key2_ff;
   time_ms_type   in_now_ff;
   logic          in_advance;
   logic          req_transfer;

   // tracking state
   phase_type     phase_ff;
   phase_type     phase_in;
   key_code_type  held_key_ff;
   key_code_type  held_key_in;
   time_ms_type   mark_ff;
   time_ms_type   mark_in;

   // result register
   logic          rsp_valid_ff;
   key_code_type  rsp_code_ff;
   key_code_type  report;

   // poll logic
   key_code_type  sensed;
   time_ms_type   elapsed;
   logic          over_debounce;
   logic          over_hold;
   logic          over_repeat;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RESET;
         hold_ff     <= HOLD_RESET;
         repeat_ff   <= REPEAT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_DEBOUNCE: debounce_ff <= csr_pwdata[SetWidth-1:0];
            REG_HOLD:     hold_ff     <= csr_pwdata[SetWidth-1:0];
            REG_REPEAT:   repeat_ff   <= csr_pwdata[SetWidth-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      case (csr_index)
         REG_DEBOUNCE: csr_prdata[SetWidth-1:0] = debounce_ff;
         REG_HOLD:     csr_prdata[SetWidth-1:0] = hold_ff;
         REG_REPEAT:   csr_prdata[SetWidth-1:0] = repeat_ff;
         default:      csr_prdata = '0;
      endcase
   end

   // handshake between the two registers
   assign in_advance   = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready   = ~in_valid_ff | in_advance;
   assign req_transfer = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_key1_ff <= req_tdata[0];
         in_key2_ff <= req_tdata[1];
         in_now_ff  <= req_tdata[TimeWidth+1:2];
      end
   end

   // sensed key and elapsed-time compares
   always_comb begin
      if (!in_key2_ff) begin
         sensed = KEY_TWO;
      end else if (!in_key1_ff) begin
         sensed = KEY_ONE;
      end else begin
         sensed = KEY_NONE;
      end
   end

   assign elapsed       = in_now_ff - mark_ff;
   assign over_debounce = elapsed > {{(TimeWidth-SetWidth){1'b0}}, debounce_ff};
   assign over_hold     = elapsed > {{(TimeWidth-SetWidth){1'b0}}, hold_ff};
   assign over_repeat   = elapsed > {{(TimeWidth-SetWidth){1'b0}}, repeat_ff};

   // phase transitions
   always_comb begin
      phase_in    = phase_ff;
      held_key_in = held_key_ff;
      mark_in     = mark_ff;
      report      = KEY_NONE;
      unique case (phase_ff)
         PH_UP: begin
            if (sensed != KEY_NONE) begin
               held_key_in = sensed;
               mark_in     = in_now_ff;
               phase_in    = PH_DEBOUNCE;
            end else begin
               held_key_in = KEY_NONE;
            end
         end
         PH_DEBOUNCE: begin
            if (sensed == KEY_NONE) begin
               phase_in    = PH_UP;
               held_key_in = KEY_NONE;
            end else if (sensed != held_key_ff) begin
               mark_in     = in_now_ff;
               held_key_in = sensed;
            end else if (over_debounce) begin
               phase_in = PH_PRESSED;
               mark_in  = in_now_ff;
               report   = held_key_ff;
            end
         end
         PH_PRESSED: begin
            if (sensed == KEY_NONE) begin
               phase_in = PH_RELEASED;
            end else if (sensed == held_key_ff) begin
               phase_in = PH_DOWN;
            end else begin
               phase_in = PH_DEBOUNCE;
            end
            mark_in = in_now_ff;
         end
         PH_DOWN: begin
            if (sensed != held_key_ff) begin
               phase_in = PH_RELEASED;
               mark_in  = in_now_ff;
            end else if (over_hold) begin
               phase_in = PH_HELD;
               mark_in  = in_now_ff;
            end
         end
         PH_HELD: begin
            if (sensed != held_key_ff) begin
               phase_in = PH_RELEASED;
               mark_in  = in_now_ff;
               report   = held_key_ff;
            end else if (over_repeat) begin
               mark_in = in_now_ff;
               report  = held_key_ff;
            end
         end
         PH_RELEASED: begin
            if (sensed == KEY_NONE) begin
               phase_in = PH_UP;
            end else begin
               phase_in    = PH_DEBOUNCE;
               held_key_in = sensed;
               mark_in     = in_now_ff;
            end
         end
         default: begin
            phase_in    = PH_UP;
            held_key_in = KEY_NONE;
            mark_in     = '0;
         end
      endcase
   end

   // state update as a poll leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_UP;
         held_key_ff <= KEY_NONE;
         mark_ff     <= '0;
      end else if (in_advance) begin
         phase_ff    <= phase_in;
         held_key_ff <= held_key_in;
         mark_ff     <= mark_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_advance) begin
         rsp_code_ff <= report;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-CodeWidth){1'b0}}, rsp_code_ff};

`ifndef ASSERT_OFF
   // a reported code never takes the unused code
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3))
      else $error("key code out of range");

   // only debounce completion or the held phase report a key
   a_report_phase: assert property (@(posedge clock) disable iff (reset)
      (in_advance && report != KEY_NONE) |->
         (phase_ff == PH_DEBOUNCE || phase_ff == PH_HELD))
      else $error("key reported from a wrong phase");

   // the tracked key never takes the unused code
   a_held_key: assert property (@(posedge clock) disable iff (reset)
      held_key_ff != 2'd3)
      else $error("held key out of range");

   // in the down and held phases a key is always being tracked
   a_tracked: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DOWN || phase_ff == PH_HELD) |-> held_key_ff != KEY_NONE)
      else $error("down or held without a key");

   // debounce and hold settings come out of reset at their defaults
   a_reset_set: assert property (@(posedge clock)
      $past(reset) |-> (debounce_ff == DEBOUNCE_RESET && hold_ff == HOLD_RESET))
      else $error("settings not at reset values");
`endif

endmodule : key_debounce_hold_repeat_core
`default_nettype wire

// ===== verif/key_debounce_hold_repeat_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// key_debounce_hold_repeat_core_tb
// Self-checking bench for the two-key debouncer with hold and auto-repeat.
// Polls go in on the req_ stream and key codes come back on rsp_. A class
// tracks the key phases alongside the block and queues one code per poll.
// Each code that comes back is compared with the oldest one in that queue.
// A directed run goes through every phase, the timer wrap and the zero
// settings. Randomised key presses with bounce, key swaps and noise follow,
// under several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module key_debounce_hold_repeat_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kdhr_pkg::*;

   localparam int unsigned WatchdogLimit = 3000;
   localparam int unsigned HoldOffCycles = 300;
   localparam int unsigned SettleCycles  = 4;
   localparam int unsigned DrainCycles   = 8;

   // register index with no register behind it
   localparam logic [1:0] REG_SPARE = 2'd3;

   // ------------------------------------------------------------------------
   // key tracker: predicts one key code per poll and checks the results
   // ------------------------------------------------------------------------
   class key_tracker;
      set_ms_type   debounce_set;
      set_ms_type   hold_set;
      set_ms_type   repeat_set;
      phase_type    phase;
      key_code_type tracked_key;
      time_ms_type  mark_ms;
      key_code_type due_codes[$];
      int           errors;
      int           polls;
      int           codes_seen[3];

      function new();
         debounce_set = DEBOUNCE_RESET;
         hold_set     = HOLD_RESET;
         repeat_set   = REPEAT_RESET;
         phase        = PH_UP;
         tracked_key  = KEY_NONE;
         mark_ms      = '0;
         errors       = 0;
         polls        = 0;
         codes_seen   = '{0, 0, 0};
      endfunction

      function int pending();
         return due_codes.size();
      endfunction

      // register write; out-of-range index is dropped
      function void set_register(logic [1:0] index, logic [CsrDataWidth-1:0] value);
         case (index)
            REG_DEBOUNCE: debounce_set = value[SetWidth-1:0];
            REG_HOLD:     hold_set     = value[SetWidth-1:0];
            REG_REPEAT:   repeat_set   = value[SetWidth-1:0];
            default: ;
         endcase
      endfunction

      function void check_setting(logic [1:0] index, logic [CsrDataWidth-1:0] value);
         set_ms_type want;
         case (index)
            REG_DEBOUNCE: want = debounce_set;
            REG_HOLD:     want = hold_set;
            default:      want = repeat_set;
         endcase
         if (value[SetWidth-1:0] !== want) begin
            $error("register %0d: expected %0d, got %0d", index, want, value[SetWidth-1:0]);
            errors++;
         end
      endfunction

      // strict compare of the wrapped elapsed time
      function bit past_limit(time_ms_type now, set_ms_type limit);
         time_ms_type gap;
         gap = now - mark_ms;
         return gap > {16'd0, limit};
      endfunction

      // one accepted poll: step the phase machine and queue its code
      function void note_poll(logic [ReqDataWidth-1:0] data);
         time_ms_type  now;
         key_code_type sensed;
         key_code_type report;
         now    = data[TimeWidth+1:2];
         sensed = KEY_NONE;
         report = KEY_NONE;
         if (!data[0]) sensed = KEY_ONE;
         if (!data[1]) sensed = KEY_TWO;
         polls++;
         case (phase)
            PH_UP: begin
               if (sensed != KEY_NONE) begin
                  tracked_key = sensed;
                  mark_ms     = now;
                  phase       = PH_DEBOUNCE;
               end else begin
                  tracked_key = KEY_NONE;
               end
            end
            PH_DEBOUNCE: begin
               if (sensed == KEY_NONE) begin
                  phase       = PH_UP;
                  tracked_key = KEY_NONE;
               end else if (sensed != tracked_key) begin
                  // bounce onto the other key restarts the wait
                  mark_ms     = now;
                  tracked_key = sensed;
               end else if (past_limit(now, debounce_set)) begin
                  phase   = PH_PRESSED;
                  mark_ms = now;
                  report  = tracked_key;
               end
            end
            PH_PRESSED: begin
               // key swap goes back to debounce, tracked key kept for now
               if (sensed == KEY_NONE)
                  phase = PH_RELEASED;
               else if (sensed == tracked_key)
                  phase = PH_DOWN;
               else
                  phase = PH_DEBOUNCE;
               mark_ms = now;
            end
            PH_DOWN: begin
               if (sensed != tracked_key) begin
                  phase   = PH_RELEASED;
                  mark_ms = now;
               end else if (past_limit(now, hold_set)) begin
                  phase   = PH_HELD;
                  mark_ms = now;
               end
            end
            PH_HELD: begin
               // leaving held reports the key that was held
               if (sensed != tracked_key) begin
                  phase   = PH_RELEASED;
                  mark_ms = now;
                  report  = tracked_key;
               end else if (past_limit(now, repeat_set)) begin
                  mark_ms = now;
                  report  = tracked_key;
               end
            end
            PH_RELEASED: begin
               if (sensed == KEY_NONE) begin
                  phase = PH_UP;
               end else begin
                  phase       = PH_DEBOUNCE;
                  tracked_key = sensed;
                  mark_ms     = now;
               end
            end
            default: begin
               phase       = PH_UP;
               tracked_key = KEY_NONE;
               mark_ms     = '0;
            end
         endcase
         due_codes.push_back(report);
      endfunction

      // one accepted result against the oldest queued code
      function void check_report(logic [RspDataWidth-1:0] data);
         key_code_type due;
         if (due_codes.size() == 0) begin
            $error("key_code %0d arrived with no poll outstanding", data[CodeWidth-1:0]);
            errors++;
         end else begin
            due = due_codes.pop_front();
            codes_seen[due]++;
            if (data[CodeWidth-1:0] !== due) begin
               $error("key_code: expected %0d, got %0d", due, data[CodeWidth-1:0]);
               errors++;
            end
            if (data[RspDataWidth-1:CodeWidth] !== '0) begin
               $error("rsp padding: expected 0, got %0h", data[RspDataWidth-1:CodeWidth]);
               errors++;
            end
         end
      endfunction
   endclass

   // ------------------------------------------------------------------------
   // block under test
   // ------------------------------------------------------------------------
   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   // [0] key1_level, [1] key2_level, [33:2] now_ms, [39:34] zero
   logic [ReqDataWidth-1:0] req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   // [1:0] key_code, [7:2] zero
   logic [RspDataWidth-1:0] rsp_tdata;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [CsrAddrWidth-1:0] csr_paddr;
   logic [CsrDataWidth-1:0] csr_pwdata;
   logic [CsrDataWidth-1:0] csr_prdata;
   logic                    csr_pready;

   key_debounce_hold_repeat_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   key_tracker  tracker;
   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;
   int          polls_sent     = 0;
   int          hold_off_at    = -1;
   int          csr_writes     = 0;
   logic        hold_off_pending = 1'b0;
   int unsigned quiet_cycles   = 0;
   time_ms_type poll_ms;

   // clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ------------------------------------------------------------------------
   // monitor: notes polls, checks results, watchdog on stalled traffic
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) tracker.note_poll(req_tdata);
         if (rsp_tvalid && rsp_tready) tracker.check_report(rsp_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WatchdogLimit) begin
            $display("key_debounce_hold_repeat_core_tb: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // receiver: random stalls, and one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready = 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
         end
         rsp_tready = ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   // one poll transfer, returns just after the accepting edge
   task automatic send_poll(input logic k1, input logic k2, input time_ms_type now);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {6'd0, now, k2, k1};
      do @(posedge clock); while (!req_tready);
      polls_sent++;
      if (polls_sent == hold_off_at) hold_off_pending = 1'b1;
   endtask

   // poll with the pins set for a key code, time moved on by a random step
   task automatic poll_code(input key_code_type code, input int unsigned max_step);
      logic k1;
      logic k2;
      k1 = 1'b1;
      k2 = 1'b1;
      case (code)
         KEY_ONE: k1 = 1'b0;
         KEY_TWO: begin
            k2 = 1'b0;
            k1 = 1'($urandom_range(1));
         end
         default: ;
      endcase
      poll_ms = poll_ms + $urandom_range(max_step);
      send_poll(k1, k2, poll_ms);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [CsrDataWidth-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_register(index, value);
      csr_writes++;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic csr_read_check(input logic [1:0] index);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = {index, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.check_setting(index, csr_prdata);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   // wait for the block to drain, then load all three settings
   task automatic configure(input set_ms_type deb, input set_ms_type hold,
                            input set_ms_type rep);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      csr_write(REG_DEBOUNCE, {16'($urandom()), deb});
      csr_write(REG_HOLD,     {16'($urandom()), hold});
      csr_write(REG_REPEAT,   {16'($urandom()), rep});
      csr_write(REG_SPARE,    $urandom());
      csr_read_check(REG_DEBOUNCE);
      csr_read_check(REG_HOLD);
      csr_read_check(REG_REPEAT);
   endtask

   // random key traffic: mostly clean presses with bounce, some noise
   task automatic key_traffic(input int count, input int unsigned max_step);
      int           sent;
      int           len;
      key_code_type code;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 85) begin
            code = $urandom_range(1) ? KEY_TWO : KEY_ONE;
            // contact bounce before the key settles
            repeat ($urandom_range(3)) begin
               poll_ms = poll_ms + $urandom_range(max_step);
               send_poll(1'($urandom_range(1)), 1'($urandom_range(1)), poll_ms);
               sent++;
            end
            len = $urandom_range(60, 1);
            repeat (len) begin
               // occasional swap to the other key mid-press
               if ($urandom_range(99) < 3) code = (code == KEY_ONE) ? KEY_TWO : KEY_ONE;
               poll_code(code, max_step);
               sent++;
            end
            repeat ($urandom_range(4, 1)) begin
               poll_code(KEY_NONE, max_step);
               sent++;
            end
         end else begin
            if ($urandom_range(9) == 0) poll_ms = $urandom();
            poll_ms = poll_ms + $urandom_range(max_step);
            send_poll(1'($urandom_range(1)), 1'($urandom_range(1)), poll_ms);
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      tracker     = new();
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      poll_ms     = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed walk at reset settings, across the timer wrap
      send_poll(1'b1, 1'b1, 32'd0);
      send_poll(1'b0, 1'b1, 32'hFFFF_FFF0);
      send_poll(1'b0, 1'b1, 32'd4);        // elapsed equals debounce, no report
      send_poll(1'b0, 1'b1, 32'd5);        // debounce done, key one
      send_poll(1'b1, 1'b0, 32'd6);        // key swap while pressed
      send_poll(1'b1, 1'b0, 32'd7);        // debounce takes key two
      send_poll(1'b0, 1'b0, 32'd28);       // both low, key two wins
      send_poll(1'b0, 1'b0, 32'd29);       // down
      send_poll(1'b1, 1'b0, 32'd1029);     // elapsed equals hold
      send_poll(1'b1, 1'b0, 32'd1030);     // held
      send_poll(1'b1, 1'b0, 32'd1230);     // elapsed equals repeat
      send_poll(1'b1, 1'b0, 32'd1231);     // auto-repeat
      send_poll(1'b0, 1'b1, 32'd1232);     // key change while held, release report
      send_poll(1'b0, 1'b1, 32'd1233);     // released straight into debounce
      send_poll(1'b1, 1'b1, 32'd1234);     // bounce back up
      send_poll(1'b0, 1'b1, 32'd2000);
      send_poll(1'b0, 1'b1, 32'd2021);
      send_poll(1'b0, 1'b1, 32'd2022);
      send_poll(1'b1, 1'b0, 32'd2023);     // key change while down
      send_poll(1'b1, 1'b1, 32'd2024);

      // zero settings: one millisecond is enough
      configure(16'd0, 16'd0, 16'd0);
      send_poll(1'b0, 1'b1, 32'hFFFF_FFFF);
      send_poll(1'b0, 1'b1, 32'hFFFF_FFFF);
      send_poll(1'b0, 1'b1, 32'd0);
      send_poll(1'b1, 1'b1, 32'd1);        // release while pressed
      send_poll(1'b1, 1'b0, 32'd2);

      // random phases, small settings so that every phase is reached
      poll_ms = 32'hFFFF_FF00;
      configure(16'($urandom_range(6)), 16'($urandom_range(40)), 16'($urandom_range(8)));
      key_traffic(400, 4);

      configure(16'($urandom_range(6)), 16'($urandom_range(40)), 16'($urandom_range(8)));
      send_idle_pct = 76;
      key_traffic(400, 4);

      configure(16'($urandom_range(6)), 16'($urandom_range(40)), 16'($urandom_range(8)));
      send_idle_pct = 0;
      rsp_stall_pct = 76;
      hold_off_at   = polls_sent + 100;
      key_traffic(400, 4);

      configure(16'd0, 16'd0, 16'd0);
      send_idle_pct = 21;
      rsp_stall_pct = 21;
      key_traffic(350, 3);

      // top settings with large time steps
      configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
      key_traffic(300, 40000);

      // drain and finish
      @(negedge clock);
      req_tvalid = 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("%0d polls, codes: none %0d, key one %0d, key two %0d",
               tracker.polls, tracker.codes_seen[0], tracker.codes_seen[1],
               tracker.codes_seen[2]);
      $display("%0d register writes, settings 0 to 65535, idling mixes and one long hold-off",
               csr_writes);
      if (tracker.errors == 0)
         $display("key_debounce_hold_repeat_core_tb: done, clean");
      else
         $display("key_debounce_hold_repeat_core_tb: done, errors");
      $finish;
   end

endmodule : key_debounce_hold_repeat_core_tb
`default_nettype wire
